// ===== rtl/stack_extract_min_assert.svh =====
// Assertion macros for the stack with extract-minimum
`ifndef STACK_EXTRACT_MIN_ASSERT_SVH
`define STACK_EXTRACT_MIN_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define SXM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define SXM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sxm_pkg.sv =====
// Shared types, codes and widths for the stack with extract-minimum
package sxm_pkg;

  localparam int DATA_W        = 32;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;
  localparam int COUNT_OUT_W   = 7;
  localparam int DEFAULT_DEPTH = 64;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_PUSH    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXTRACT = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SCAN,
    S_SHIFT,
    S_DELIVER
  } sxm_state_t;

endpackage

// ===== rtl/sxm_if.sv =====
// Request and response channel interfaces for the stack with extract-minimum
interface sxm_req_if import sxm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, mode, push_value, input ready);
  modport sink   (input valid, mode, push_value, output ready);
endinterface

interface sxm_rsp_if import sxm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] out_value;
  logic [STATUS_W-1:0]      status;
  logic [COUNT_OUT_W-1:0]   entry_count;

  modport source (output valid, out_value, status, entry_count, input ready);
  modport sink   (input valid, out_value, status, entry_count, output ready);
endinterface

// ===== rtl/stack_extract_min.sv =====
// Bounded LIFO stack of signed words with push, pop and extract-minimum.
// One operation is handled at a time; the next request is taken as soon as the
// previous one has reached the response register. The entries live in one
// memory with one read and one write port and registered read data. Push writes
// the new top entry when the request is taken, pop reads the top entry, and
// extract-minimum scans the held entries top-down, one entry per cycle, for the
// smallest value (the copy nearest the top wins a tie), then moves each entry
// above it down by one, one entry per cycle. An empty pop or extract, a push
// onto a full stack and the unused mode code go straight to the response
// register. While the response register still holds an untaken result, a
// finished operation waits and the request side stays closed. No clearing pass
// after reset; only held entries are ever read.
`include "stack_extract_min_assert.svh"

module stack_extract_min import sxm_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  sxm_req_if.sink      req,
  sxm_rsp_if.source    rsp
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // Entry storage
  logic [DATA_W-1:0]        mem [STACK_DEPTH];
  logic signed [DATA_W-1:0] rd_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [DATA_W-1:0]        wr_data;

  // Control and datapath registers
  sxm_state_t               state, state_next;
  logic [CW-1:0]            count;
  logic [AW-1:0]            scan_idx;
  logic                     scan_first;
  logic signed [DATA_W-1:0] best_val;
  logic [AW-1:0]            best_idx;
  logic [AW-1:0]            sh_idx;
  logic signed [DATA_W-1:0] res_value;
  logic [STATUS_W-1:0]      res_status;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_value;
  logic [STATUS_W-1:0]      out_status;
  logic [COUNT_OUT_W-1:0]   out_count;

  logic                     accept;
  logic                     deliver;
  logic                     full;
  logic                     empty;
  logic [AW-1:0]            top_idx;
  logic [CW-1:0]            count_dec;
  logic                     take;
  logic signed [DATA_W-1:0] best_val_new;
  logic [AW-1:0]            best_idx_new;
  logic [CW+COUNT_OUT_W-1:0] count_wide;

  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(STACK_DEPTH));
  assign empty     = (count == '0);
  assign count_dec = count - 1'b1;
  assign top_idx   = count_dec[AW-1:0];
  assign count_wide = {{COUNT_OUT_W{1'b0}}, count};

  // Running minimum over the word arriving from memory; strict compare keeps
  // the copy nearest the top on a tie
  assign take         = scan_first || (rd_data < best_val);
  assign best_val_new = take ? rd_data : best_val;
  assign best_idx_new = take ? scan_idx : best_idx;

  // Memory write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Memory read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          case (req.mode)
            MODE_POP:     state_next = empty ? S_DELIVER : S_POP_RD;
            MODE_EXTRACT: state_next = empty ? S_DELIVER : S_SCAN;
            default:      state_next = S_DELIVER;
          endcase
        end
      end
      S_POP_RD: state_next = S_DELIVER;
      S_SCAN: begin
        if (scan_idx == '0) begin
          state_next = (best_idx_new == top_idx) ? S_DELIVER : S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sh_idx == top_idx) begin
          state_next = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (!out_valid || rsp.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory port controls
  always_comb begin
    req.ready = 1'b0;
    deliver   = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = top_idx;
    wr_en     = 1'b0;
    wr_addr   = count[AW-1:0];
    wr_data   = req.push_value;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          case (req.mode)
            MODE_PUSH:    wr_en = !full;
            MODE_POP:     rd_en = !empty;
            MODE_EXTRACT: rd_en = !empty;
            default:      ;
          endcase
        end
      end
      S_POP_RD: ;
      S_SCAN: begin
        if (scan_idx != '0) begin
          rd_en   = 1'b1;
          rd_addr = scan_idx - 1'b1;
        end else if (best_idx_new != top_idx) begin
          rd_en   = 1'b1;
          rd_addr = best_idx_new + 1'b1;
        end
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = sh_idx - 1'b1;
        wr_data = rd_data;
        if (sh_idx != top_idx) begin
          rd_en   = 1'b1;
          rd_addr = sh_idx + 1'b1;
        end
      end
      S_DELIVER: deliver = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  // State and stack count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept && req.mode == MODE_PUSH && !full) begin
        count <= count + 1'b1;
      end else if (accept && req.mode == MODE_POP && !empty) begin
        count <= count_dec;
      end else if ((state == S_SCAN && scan_idx == '0 && best_idx_new == top_idx)
                   || (state == S_SHIFT && sh_idx == top_idx)) begin
        count <= count_dec;
      end
    end
  end

  // Scan, shift and result working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        scan_idx   <= top_idx;
        scan_first <= 1'b1;
        res_value  <= '0;
        res_status <= ST_OK;
        if (req.valid) begin
          case (req.mode)
            MODE_PUSH:    res_status <= full ? ST_FULL : ST_OK;
            MODE_POP:     res_status <= empty ? ST_EMPTY : ST_OK;
            MODE_EXTRACT: res_status <= empty ? ST_EMPTY : ST_OK;
            default:      ;
          endcase
        end
      end
      S_POP_RD: res_value <= rd_data;
      S_SCAN: begin
        scan_first <= 1'b0;
        best_val   <= best_val_new;
        best_idx   <= best_idx_new;
        scan_idx   <= scan_idx - 1'b1;
        sh_idx     <= best_idx_new + 1'b1;
        if (scan_idx == '0) begin
          res_value <= best_val_new;
        end
      end
      S_SHIFT: sh_idx <= sh_idx + 1'b1;
      default: ;
    endcase
  end

  // Response register: hold until transfer, load a new result when free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (deliver) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_value  <= res_value;
      out_status <= res_status;
      out_count  <= count_wide[COUNT_OUT_W-1:0];
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.out_value   = out_value;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;

  // Checks
  `SXM_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(STACK_DEPTH),
    "stack count above depth")
  `SXM_ASSERT_NOW(a_port_clash, rd_en && wr_en, rd_addr != wr_addr,
    "read and write of the same entry in one cycle")
  `SXM_ASSERT_NOW(a_shift_writes, state == S_SHIFT, wr_en,
    "gap-closing cycle without a write")
  `SXM_ASSERT_NEXT(a_pop_count, accept && req.mode == MODE_POP && !empty,
    count == $past(count_dec), "pop did not lower the count by one")

endmodule
